// ===== hdl/pixel_blend_unit_assert.svh =====
// ---------------------------------------------------------------------------
// pixel_blend_unit assertion macros
// shared property forms for the checker of the blend unit
// ---------------------------------------------------------------------------
`ifndef PIXEL_BLEND_UNIT_ASSERT_SVH
`define PIXEL_BLEND_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PBU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel_blend_unit: same-cycle property failed");

// next-cycle implication, disabled while reset is asserted
`define PBU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel_blend_unit: next-cycle property failed");

`endif

// ===== hdl/pbu_pkg.sv =====
// ---------------------------------------------------------------------------
// pbu_pkg
// types, constants and register map of the pixel blend unit
// ---------------------------------------------------------------------------
package pbu_pkg;

	localparam int MAX_DIM  = 4096;
	localparam int DIM_W    = 13;
	localparam int COORD_W  = 14;
	localparam int CHAN_W   = 8;
	localparam int ADDR_W   = 26;
	localparam int PROD_W   = 2 * CHAN_W;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 13;
	localparam int LANES    = 4;

	// largest effective dimension: MAX_DIM, or the 13-bit maximum if that is smaller
	localparam int DIM_CAP = (MAX_DIM > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1 : MAX_DIM;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_BLEND_ENABLE = 3'd2;
	localparam logic [IDX_W-1:0] REG_BLEND_MODE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_BLEND_ALPHA  = 3'd4;

	localparam logic [CHAN_W-1:0] MODE_REPLACE = 8'd0;
	localparam logic [CHAN_W-1:0] MODE_ADD     = 8'd1;
	localparam logic [CHAN_W-1:0] MODE_MAX     = 8'd2;
	localparam logic [CHAN_W-1:0] MODE_AVG     = 8'd3;
	localparam logic [CHAN_W-1:0] MODE_SUB     = 8'd4;
	localparam logic [CHAN_W-1:0] MODE_REVSUB  = 8'd5;
	localparam logic [CHAN_W-1:0] MODE_MUL     = 8'd6;
	localparam logic [CHAN_W-1:0] MODE_ALPHA   = 8'd7;
	localparam logic [CHAN_W-1:0] MODE_XOR     = 8'd8;
	localparam logic [CHAN_W-1:0] MODE_MIN     = 8'd9;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
	localparam logic [CHAN_W-1:0] ROUND_HALF = 8'd127;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
		logic              blend_enable;
		logic [CHAN_W-1:0] blend_mode;
		logic [CHAN_W-1:0] blend_alpha;
	} cfg_t;

	typedef logic [CHAN_W-1:0] chan_t;

endpackage

// ===== hdl/pbu_if.sv =====
// ---------------------------------------------------------------------------
// pbu channel interfaces
// pixel request channel and blended result channel, valid/ready
// ---------------------------------------------------------------------------
interface pbu_pixel_if;
	import pbu_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pixel_x;
	logic signed [COORD_W-1:0] pixel_y;
	logic [CHAN_W-1:0]         dest_red;
	logic [CHAN_W-1:0]         dest_green;
	logic [CHAN_W-1:0]         dest_blue;
	logic [CHAN_W-1:0]         dest_alpha;
	logic [CHAN_W-1:0]         src_red;
	logic [CHAN_W-1:0]         src_green;
	logic [CHAN_W-1:0]         src_blue;
	logic [CHAN_W-1:0]         src_alpha;

	modport source (
		output valid, pixel_x, pixel_y, dest_red, dest_green, dest_blue, dest_alpha,
		output src_red, src_green, src_blue, src_alpha,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, dest_red, dest_green, dest_blue, dest_alpha,
		input  src_red, src_green, src_blue, src_alpha,
		output ready
	);
endinterface

interface pbu_result_if;
	import pbu_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic [CHAN_W-1:0] out_alpha;
	logic              write_enable;
	logic [ADDR_W-1:0] byte_address;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha, write_enable, byte_address,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha, write_enable, byte_address,
		output ready
	);
endinterface

// ===== hdl/pixel_blend_unit.sv =====
// ---------------------------------------------------------------------------
// pixel_blend_unit
// per-pixel RGBA blend and address stage of a framebuffer write path
// ---------------------------------------------------------------------------
// The pixel channel carries a coordinate, the destination RGBA pixel read
// from the framebuffer and the source colour. The result channel returns the
// blended RGBA value, a write enable (coordinate inside the frame) and the
// byte address (y*width+x)*4, zero when the write is suppressed.
// Four channel lanes run side by side; a merging register gathers their
// channels with the address unit into one result transfer.
// A pixel transfer passes through two registered stages: stage 1
// holds the lane products and the row multiply, stage 2 the rounded /255,
// column add and result. One pixel per clock while results are taken.
// The user must write the registers via cfg_we/cfg_index/cfg_data only
// while no pixel is in flight; the block does not enforce this. Indexes
// beyond the map are ignored. Reset clears the valid bits of both stages
// and loads the register reset values (640 x 480, blending off). When the
// receiver stalls, the result holds and stage 1 still takes one more pixel
// if empty; after that ready drops until the result is taken.
// ---------------------------------------------------------------------------
module pixel_blend_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	pbu_pixel_if.sink                     pixel,
	pbu_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [pbu_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pbu_pkg::DATA_W-1:0]    cfg_data
);
	import pbu_pkg::*;

	cfg_t  cfg_q;
	logic  valid_s1;
	logic  valid_s2;
	logic  adv_s2;
	logic  load_s1;
	logic  load_s2;

	chan_t lane_dest [LANES];
	chan_t lane_src  [LANES];
	chan_t lane_out  [LANES];
	logic  frame_hit;
	logic [ADDR_W-1:0] addr;

	chan_t             chan_s2 [LANES];
	logic              write_enable_s2;
	logic [ADDR_W-1:0] byte_address_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= WIDTH_RESET;
			cfg_q.frame_height <= HEIGHT_RESET;
			cfg_q.blend_enable <= 1'b0;
			cfg_q.blend_mode   <= MODE_REPLACE;
			cfg_q.blend_alpha  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				REG_BLEND_ENABLE: cfg_q.blend_enable <= cfg_data[0];
				REG_BLEND_MODE:   cfg_q.blend_mode   <= cfg_data[CHAN_W-1:0];
				REG_BLEND_ALPHA:  cfg_q.blend_alpha  <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 refills whenever it is empty or the result register moves on or is empty
	assign adv_s2      = !valid_s2 || result.ready;
	assign pixel.ready = !valid_s1 || adv_s2;
	assign load_s1     = pixel.valid && pixel.ready;
	assign load_s2     = adv_s2 && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel.ready) begin
				valid_s1 <= pixel.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign lane_dest[0] = pixel.dest_red;
	assign lane_dest[1] = pixel.dest_green;
	assign lane_dest[2] = pixel.dest_blue;
	assign lane_dest[3] = pixel.dest_alpha;
	assign lane_src[0]  = pixel.src_red;
	assign lane_src[1]  = pixel.src_green;
	assign lane_src[2]  = pixel.src_blue;
	assign lane_src[3]  = pixel.src_alpha;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		pbu_lane u_lane (
			.clk     (clk),
			.load_s1 (load_s1),
			.dest    (lane_dest[i]),
			.src     (lane_src[i]),
			.cfg     (cfg_q),
			.blended (lane_out[i])
		);
	end

	pbu_addr u_addr (
		.clk          (clk),
		.load_s1      (load_s1),
		.pixel_x      (pixel.pixel_x),
		.pixel_y      (pixel.pixel_y),
		.cfg          (cfg_q),
		.frame_hit    (frame_hit),
		.byte_address (addr)
	);

	// merge stage: lane channels and address into one result register
	always_ff @(posedge clk) begin
		if (load_s2) begin
			for (int i = 0; i < LANES; i++) begin
				chan_s2[i] <= lane_out[i];
			end
			write_enable_s2 <= frame_hit;
			byte_address_s2 <= addr;
		end
	end

	assign result.valid        = valid_s2;
	assign result.out_red      = chan_s2[0];
	assign result.out_green    = chan_s2[1];
	assign result.out_blue     = chan_s2[2];
	assign result.out_alpha    = chan_s2[3];
	assign result.write_enable = write_enable_s2;
	assign result.byte_address = byte_address_s2;

endmodule

// ===== hdl/pbu_lane.sv =====
// ---------------------------------------------------------------------------
// pbu_lane
// one colour channel: mode select and products in stage 1, rounding /255
// ---------------------------------------------------------------------------
module pbu_lane (
	input  logic                 clk,
	input  logic                 load_s1,
	input  pbu_pkg::chan_t       dest,
	input  pbu_pkg::chan_t       src,
	input  pbu_pkg::cfg_t        cfg,
	output pbu_pkg::chan_t       blended
);
	import pbu_pkg::*;

	logic [PROD_W-1:0] prod0_s1;
	logic [PROD_W-1:0] prod1_s1;
	chan_t             simple_s1;
	logic              use_div_s1;

	chan_t             simple;
	logic              use_div;
	chan_t             mul_b;
	logic [CHAN_W:0]   chan_sum;
	logic [CHAN_W:0]   chan_avg;
	logic [PROD_W:0]   round_sum;
	logic [PROD_W:0]   quot;

	always_comb begin
		chan_sum = {1'b0, dest} + {1'b0, src};
		chan_avg = chan_sum + (CHAN_W+1)'(1);
		use_div  = 1'b0;
		simple   = src;
		if (cfg.blend_enable) begin
			case (cfg.blend_mode)
				MODE_ADD:    simple = chan_sum[CHAN_W] ? CHAN_MAX : chan_sum[CHAN_W-1:0];
				MODE_MAX:    simple = (dest > src) ? dest : src;
				MODE_AVG:    simple = chan_avg[CHAN_W:1];
				MODE_SUB:    simple = (dest > src) ? dest - src : '0;
				MODE_REVSUB: simple = (src > dest) ? src - dest : '0;
				MODE_XOR:    simple = dest ^ src;
				MODE_MIN:    simple = (dest < src) ? dest : src;
				MODE_MUL,
				MODE_ALPHA:  use_div = 1'b1;
				default:     simple = src;
			endcase
		end
		// 255 - alpha is the bitwise complement for an 8-bit weight
		mul_b = (cfg.blend_mode == MODE_ALPHA) ? ~cfg.blend_alpha : src;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			prod0_s1   <= dest * mul_b;
			prod1_s1   <= (cfg.blend_mode == MODE_ALPHA) ? src * cfg.blend_alpha : '0;
			simple_s1  <= simple;
			use_div_s1 <= use_div;
		end
	end

	// divide by 255 through (t + 1 + t/256) / 256, exact for t below 65535
	always_comb begin
		round_sum = {1'b0, prod0_s1} + {1'b0, prod1_s1} + (PROD_W+1)'(ROUND_HALF);
		quot      = (round_sum + (PROD_W+1)'(1) + (round_sum >> CHAN_W)) >> CHAN_W;
		blended   = use_div_s1 ? quot[CHAN_W-1:0] : simple_s1;
	end

endmodule

// ===== hdl/pbu_addr.sv =====
// ---------------------------------------------------------------------------
// pbu_addr
// bounds check and framebuffer byte address of one pixel
// ---------------------------------------------------------------------------
module pbu_addr (
	input  logic                                clk,
	input  logic                                load_s1,
	input  logic signed [pbu_pkg::COORD_W-1:0]  pixel_x,
	input  logic signed [pbu_pkg::COORD_W-1:0]  pixel_y,
	input  pbu_pkg::cfg_t                       cfg,
	output logic                                frame_hit,
	output logic [pbu_pkg::ADDR_W-1:0]          byte_address
);
	import pbu_pkg::*;

	logic [DIM_W-1:0]    eff_width;
	logic [DIM_W-1:0]    eff_height;
	logic                in_frame;

	logic                inside_s1;
	logic [2*DIM_W-1:0]  row_base_s1;
	logic [DIM_W-1:0]    col_s1;
	logic [2*DIM_W-1:0]  pixel_index;

	always_comb begin
		eff_width  = (cfg.frame_width  > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : cfg.frame_width;
		eff_height = (cfg.frame_height > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : cfg.frame_height;
		in_frame   = !pixel_x[COORD_W-1] && !pixel_y[COORD_W-1]
			&& (pixel_x[DIM_W-1:0] < eff_width) && (pixel_y[DIM_W-1:0] < eff_height);
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			inside_s1   <= in_frame;
			row_base_s1 <= pixel_y[DIM_W-1:0] * eff_width;
			col_s1      <= pixel_x[DIM_W-1:0];
		end
	end

	always_comb begin
		pixel_index  = row_base_s1 + {{DIM_W{1'b0}}, col_s1};
		frame_hit    = inside_s1;
		byte_address = inside_s1 ? {pixel_index[ADDR_W-3:0], 2'b00} : '0;
	end

endmodule

// ===== hdl/pbu_checker.sv =====
// ---------------------------------------------------------------------------
// pbu_checker
// port-level checks of the pixel blend unit, bound to the top level
// ---------------------------------------------------------------------------
`include "pixel_blend_unit_assert.svh"

module pbu_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	input  logic                          pixel_ready,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic                          write_enable,
	input  logic [pbu_pkg::ADDR_W-1:0]    byte_address
);
	import pbu_pkg::*;

	logic pixel_xfer;
	logic result_stall;

	assign pixel_xfer   = pixel_valid && pixel_ready;
	assign result_stall = result_valid && !result_ready;

	// a stalled result stays and keeps its address
	`PBU_ASSERT_NXT(a_result_held, clk, arst_n, result_stall, result_valid && $stable(byte_address))

	// a new result only appears after a pixel transfer has passed through stage 1
	`PBU_ASSERT_IMP(a_result_origin, clk, arst_n, $rose(result_valid), $past(pixel_xfer, 2))

	// only one pixel is buffered behind a stalled result
	`PBU_ASSERT_NXT(a_one_behind, clk, arst_n, result_stall && pixel_xfer, result_ready || !pixel_ready)

	// suppressed writes carry a zero address, and addresses are word aligned
	`PBU_ASSERT_IMP(a_addr_zero, clk, arst_n, result_valid && !write_enable, byte_address == '0)
	`PBU_ASSERT_IMP(a_addr_align, clk, arst_n, result_valid, byte_address[1:0] == 2'b00)

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel.valid),
	.pixel_ready  (pixel.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.write_enable (result.write_enable),
	.byte_address (result.byte_address)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the pixel blend unit: directed corner pixels, every
// blend mode and frame dimension edge case, then randomised register settings
// with near-frame and full-range coordinates under bursty traffic and stalls
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pbu_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int PHASES       = 26;
	localparam int PHASE_PIXELS = 50;
	localparam int HOLD_PHASE   = 5;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		chan_t                     dest [LANES];
		chan_t                     src  [LANES];
	} pixel_req_t;

	typedef struct {
		chan_t             rgba [LANES];
		logic              write_enable;
		logic [ADDR_W-1:0] byte_address;
	} pixel_write_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;

	pbu_pixel_if  pix_if ();
	pbu_result_if res_if ();

	pixel_blend_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadow used for prediction
	logic [DIM_W-1:0]  fb_width  = WIDTH_RESET;
	logic [DIM_W-1:0]  fb_height = HEIGHT_RESET;
	logic              fb_blend  = 1'b0;
	logic [CHAN_W-1:0] fb_mode   = MODE_REPLACE;
	logic [CHAN_W-1:0] fb_alpha  = '0;

	pixel_req_t   pending_pixels [$];
	pixel_write_t predicted_writes [$];

	int pixels_sent;
	int pixels_taken;
	int writes_done;
	int mismatches;
	int inside_count;
	int outside_count;
	int settings_count;
	int quiet_cycles;
	int burst_left;
	int gap_left;
	int stall_run;
	logic idle_on;
	logic sender_hold;

	pixel_req_t   drive_req;
	pixel_req_t   taken_req;
	pixel_write_t want_write;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic chan_t blend_lane(chan_t d, chan_t s);
		int unsigned dv;
		int unsigned sv;
		int unsigned av;
		int unsigned r;
		dv = d;
		sv = s;
		av = fb_alpha;
		if (!fb_blend)
			return s;
		case (fb_mode)
			MODE_ADD:    r = (dv + sv > 255) ? 255 : dv + sv;
			MODE_MAX:    r = (dv > sv) ? dv : sv;
			MODE_AVG:    r = (dv + sv + 1) / 2;
			MODE_SUB:    r = (dv > sv) ? dv - sv : 0;
			MODE_REVSUB: r = (sv > dv) ? sv - dv : 0;
			MODE_MUL:    r = (dv * sv + 127) / 255;
			MODE_ALPHA:  r = (dv * (255 - av) + sv * av + 127) / 255;
			MODE_XOR:    r = dv ^ sv;
			MODE_MIN:    r = (dv < sv) ? dv : sv;
			default:     r = sv;
		endcase
		return chan_t'(r);
	endfunction

	function automatic pixel_write_t predict_write(pixel_req_t p);
		pixel_write_t pw;
		int w;
		int h;
		int xi;
		int yi;
		logic [63:0] addr;
		w  = (fb_width > MAX_DIM) ? MAX_DIM : int'(fb_width);
		h  = (fb_height > MAX_DIM) ? MAX_DIM : int'(fb_height);
		xi = p.x;
		yi = p.y;
		for (int c = 0; c < LANES; c++)
			pw.rgba[c] = blend_lane(p.dest[c], p.src[c]);
		pw.write_enable = (xi >= 0) && (yi >= 0) && (xi < w) && (yi < h);
		addr = pw.write_enable ? (64'(yi) * 64'(w) + 64'(xi)) * 4 : '0;
		pw.byte_address = addr[ADDR_W-1:0];
		return pw;
	endfunction

	// rgba words are packed as 0xRRGGBBAA
	function automatic pixel_req_t make_req(int x, int y, logic [31:0] dest_rgba,
			logic [31:0] src_rgba);
		pixel_req_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		for (int c = 0; c < LANES; c++) begin
			p.dest[c] = dest_rgba[31 - 8 * c -: 8];
			p.src[c]  = src_rgba[31 - 8 * c -: 8];
		end
		return p;
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0:       return 1;
			1:       return MAX_DIM;
			2:       return (1 << DIM_W) - 1;
			3:       return 0;
			4:       return MAX_DIM - 1;
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// mostly within the frame or up to 4 beyond its edges, sometimes anywhere in the 14-bit range
	function automatic int near_coord(logic [DIM_W-1:0] dim);
		int eff;
		eff = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, (1 << COORD_W) - 1);
		return int'($urandom_range(0, eff + 8)) - 4;
	endfunction

	function automatic chan_t rand_chan();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? CHAN_MAX : chan_t'(0);
		return chan_t'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= DATA_W'(val);
		case (idx)
			REG_FRAME_WIDTH:  fb_width  = DIM_W'(val);
			REG_FRAME_HEIGHT: fb_height = DIM_W'(val);
			REG_BLEND_ENABLE: fb_blend  = val[0];
			REG_BLEND_MODE:   fb_mode   = CHAN_W'(val);
			REG_BLEND_ALPHA:  fb_alpha  = CHAN_W'(val);
			default: ;
		endcase
		settings_count++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int w, int h, int en, int mode, int alpha);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BLEND_ENABLE, en);
		write_reg(REG_BLEND_MODE, mode);
		write_reg(REG_BLEND_ALPHA, alpha);
	endtask

	task automatic send_pixel(pixel_req_t p);
		pending_pixels = {pending_pixels, p};
		pixels_sent++;
	endtask

	// waits for every result, then lets the two-stage pipe settle
	task automatic drain();
		while (writes_done != pixels_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// pixel sender: bursts of random length separated by random gaps while idle_on is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else if (!pix_if.valid || pix_if.ready) begin
			if (idle_on && gap_left != 0) begin
				pix_if.valid <= 1'b0;
				gap_left     <= gap_left - 1;
			end else if (sender_hold || pending_pixels.size() == 0) begin
				pix_if.valid <= 1'b0;
			end else begin
				drive_req          = pending_pixels.pop_front();
				pix_if.valid      <= 1'b1;
				pix_if.pixel_x    <= drive_req.x;
				pix_if.pixel_y    <= drive_req.y;
				pix_if.dest_red   <= drive_req.dest[0];
				pix_if.dest_green <= drive_req.dest[1];
				pix_if.dest_blue  <= drive_req.dest[2];
				pix_if.dest_alpha <= drive_req.dest[3];
				pix_if.src_red    <= drive_req.src[0];
				pix_if.src_green  <= drive_req.src[1];
				pix_if.src_blue   <= drive_req.src[2];
				pix_if.src_alpha  <= drive_req.src[3];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// result receiver: alternating ready runs and stall runs while idle_on is set, else always ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_run    <= 0;
		end else if (!idle_on) begin
			res_if.ready <= 1'b1;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else if (res_if.ready) begin
			res_if.ready <= 1'b0;
			stall_run    <= $urandom_range(0, 7);
		end else begin
			res_if.ready <= 1'b1;
			stall_run    <= $urandom_range(0, 19);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (predicted_writes.size() == 0) begin
					$error("result transfer with no pixel outstanding");
					mismatches++;
				end else begin
					want_write = predicted_writes.pop_front();
					check_field("out_red", want_write.rgba[0], res_if.out_red);
					check_field("out_green", want_write.rgba[1], res_if.out_green);
					check_field("out_blue", want_write.rgba[2], res_if.out_blue);
					check_field("out_alpha", want_write.rgba[3], res_if.out_alpha);
					check_field("write_enable", want_write.write_enable,
						res_if.write_enable);
					check_field("byte_address", want_write.byte_address,
						res_if.byte_address);
					if (want_write.write_enable)
						inside_count++;
					else
						outside_count++;
					writes_done++;
				end
			end
			if (pix_if.valid && pix_if.ready) begin
				taken_req.x       = pix_if.pixel_x;
				taken_req.y       = pix_if.pixel_y;
				taken_req.dest[0] = pix_if.dest_red;
				taken_req.dest[1] = pix_if.dest_green;
				taken_req.dest[2] = pix_if.dest_blue;
				taken_req.dest[3] = pix_if.dest_alpha;
				taken_req.src[0]  = pix_if.src_red;
				taken_req.src[1]  = pix_if.src_green;
				taken_req.src[2]  = pix_if.src_blue;
				taken_req.src[3]  = pix_if.src_alpha;
				predicted_writes = {predicted_writes, predict_write(taken_req)};
				pixels_taken++;
			end
		end
	end

	// only counts while pixels are still owed a result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
					|| writes_done == pixels_sent) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		pixel_req_t p;
		int mode;
		int phase_base;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_FRAME_WIDTH;
		cfg_data          = '0;
		idle_on           = 1'b0;
		sender_hold       = 1'b0;
		pix_if.valid      = 1'b0;
		pix_if.pixel_x    = '0;
		pix_if.pixel_y    = '0;
		pix_if.dest_red   = '0;
		pix_if.dest_green = '0;
		pix_if.dest_blue  = '0;
		pix_if.dest_alpha = '0;
		pix_if.src_red    = '0;
		pix_if.src_green  = '0;
		pix_if.src_blue   = '0;
		pix_if.src_alpha  = '0;
		res_if.ready      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 640 x 480, plain replace
		send_pixel(make_req(0, 0, 32'h00000000, 32'hFFFFFFFF));
		send_pixel(make_req(639, 479, 32'hFFFFFFFF, 32'h00000000));
		send_pixel(make_req(640, 0, 32'h12345678, 32'h9ABCDEF0));
		send_pixel(make_req(0, 480, 32'hA5A5A5A5, 32'h5A5A5A5A));
		send_pixel(make_req(-1, 0, 32'h0F0F0F0F, 32'hF0F0F0F0));
		send_pixel(make_req(0, -1, 32'hFF00FF00, 32'h00FF00FF));
		send_pixel(make_req(-8192, 8191, 32'h80808080, 32'h7F7F7F7F));
		send_pixel(make_req(8191, -8192, 32'h01020304, 32'hFEFDFCFB));
		drain();

		// every mode once, unknown codes included, largest frame
		set_config(MAX_DIM, MAX_DIM, 1, MODE_REPLACE, 128);
		for (int m = 0; m < 12; m++) begin
			mode = (m <= MODE_MIN) ? m : ((m == MODE_MIN + 1) ? MODE_MIN + 1 : CHAN_MAX);
			write_reg(REG_BLEND_MODE, mode);
			if (m == 0)
				send_pixel(make_req(MAX_DIM - 1, MAX_DIM - 1, 32'h00FFC811, 32'h00FF64FA));
			else
				send_pixel(make_req(m * 7, m * 3, 32'h00FFC811, 32'h00FF64FA));
			drain();
		end
		write_reg(REG_BLEND_MODE, MODE_ALPHA);
		write_reg(REG_BLEND_ALPHA, 0);
		send_pixel(make_req(1, 1, 32'h00FF80C0, 32'hFF00407F));
		drain();
		write_reg(REG_BLEND_ALPHA, CHAN_MAX);
		send_pixel(make_req(2, 2, 32'h00FF80C0, 32'hFF00407F));
		drain();

		// zero width, then dimensions above the cap
		write_reg(REG_FRAME_WIDTH, 0);
		send_pixel(make_req(0, 0, 32'h11223344, 32'h55667788));
		drain();
		write_reg(REG_FRAME_WIDTH, (1 << DIM_W) - 1);
		write_reg(REG_FRAME_HEIGHT, (1 << DIM_W) - 1);
		send_pixel(make_req(MAX_DIM - 1, MAX_DIM - 1, 32'hFFFFFFFF, 32'hFFFFFFFF));
		send_pixel(make_req(5000, 10, 32'hFFFFFFFF, 32'h00000000));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_on = (ph % 4 != 3);
			mode = ($urandom_range(0, 4) != 0) ? $urandom_range(0, MODE_MIN)
				: $urandom_range(MODE_MIN + 1, CHAN_MAX);
			set_config(pick_dim(), pick_dim(), ($urandom_range(0, 7) != 0) ? 1 : 0, mode,
				($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? CHAN_MAX : 0)
					: $urandom_range(0, 255));
			phase_base = pixels_taken;
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				p.x = COORD_W'(near_coord(fb_width));
				p.y = COORD_W'(near_coord(fb_height));
				for (int c = 0; c < LANES; c++) begin
					p.dest[c] = rand_chan();
					p.src[c]  = rand_chan();
				end
				send_pixel(p);
			end
			if (ph == HOLD_PHASE) begin
				// hold the sender mid-phase until the pipe is empty
				while (pixels_taken < phase_base + 20)
					@(posedge clk);
				sender_hold <= 1'b1;
				@(posedge clk);
				while (writes_done != pixels_taken || pix_if.valid)
					@(posedge clk);
				sender_hold <= 1'b0;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d pixels checked over %0d register writes, %0d inside and %0d outside the frame",
			writes_done, settings_count, inside_count, outside_count);
		$display("covered all blend modes, unknown modes, alpha extremes, zero and capped dimensions");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
